// ----- hdl/lcdws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared widths, codes and types for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // Width of the enable pulse tick counter; a pulse phase ends before it is full.
  localparam int COUNT_WIDTH = 16;
  // Compare width wide enough for the counter plus one and for a 16-bit limit.
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int SETTLE_WIDTH   = 17;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_BUS_WIDTH_EIGHT      = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_NIBBLE_ON_UPPER_PINS = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_ENABLE_HIGH_TICKS    = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_ENABLE_LOW_TICKS     = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CHAR_SETTLE_TICKS    = 3'd4;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CMD_SETTLE_TICKS     = 3'd5;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CLEAR_EXTRA_TICKS    = 3'd6;

  // The display's clear command carries an extra settle time.
  localparam logic [7:0] CLEAR_CMD = 8'h01;

  // One result beat, rs_pin in the lowest bit.
  typedef struct packed {
    logic       dropped;
    logic       busy_res;
    logic [7:0] data_pins;
    logic       en_pin;
    logic       rs_pin;
  } lcdws_result_t;

  localparam int RESULT_WIDTH = $bits(lcdws_result_t);
  localparam int OUT_TDATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8;

endpackage

// ----- hdl/lcdws_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_sequencer
// Configuration registers, phase state and tick counter; works out the pin
// levels after each tick or write request in a single pass.
// ----------------------------------------------------------------------------
module lcdws_sequencer
  import lcdws_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  logic                      step,
  input  logic                      func,
  input  logic [7:0]                byte_value,
  input  logic                      is_data,
  output lcdws_result_t             result
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HIGH   = 2'd1;
  localparam logic [1:0] PH_LOW    = 2'd2;
  localparam logic [1:0] PH_SETTLE = 2'd3;

  localparam logic [CMP_WIDTH-1:0] COUNT_FULL =
    CMP_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic        bus_width_eight;
  logic        nibble_on_upper_pins;
  logic [15:0] enable_high_ticks;
  logic [15:0] enable_low_ticks;
  logic [15:0] char_settle_ticks;
  logic [15:0] cmd_settle_ticks;
  logic [15:0] clear_extra_ticks;

  logic [1:0]              phase, phase_next;
  logic                    second_nibble_pending, second_nibble_pending_next;
  logic [COUNT_WIDTH-1:0]  tick_count, tick_count_next;
  logic [7:0]              held_byte, held_byte_next;
  logic                    held_select, held_select_next;
  logic [SETTLE_WIDTH-1:0] settle_length, settle_length_next;

  logic [CMP_WIDTH-1:0]    count_inc;
  logic [15:0]             pulse_limit;
  logic                    pulse_done;
  logic [SETTLE_WIDTH-1:0] settle_load;
  logic [SETTLE_WIDTH-1:0] settle_dec;
  logic [3:0]              nibble;
  logic                    dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_width_eight      <= 1'b1;
      nibble_on_upper_pins <= 1'b1;
      enable_high_ticks    <= 16'd2;
      enable_low_ticks     <= 16'd2;
      char_settle_ticks    <= 16'd1;
      cmd_settle_ticks     <= 16'd2;
      clear_extra_ticks    <= 16'd5;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_BUS_WIDTH_EIGHT:      bus_width_eight      <= cfg_wdata[0];
        REG_NIBBLE_ON_UPPER_PINS: nibble_on_upper_pins <= cfg_wdata[0];
        REG_ENABLE_HIGH_TICKS:    enable_high_ticks    <= cfg_wdata;
        REG_ENABLE_LOW_TICKS:     enable_low_ticks     <= cfg_wdata;
        REG_CHAR_SETTLE_TICKS:    char_settle_ticks    <= cfg_wdata;
        REG_CMD_SETTLE_TICKS:     cmd_settle_ticks     <= cfg_wdata;
        REG_CLEAR_EXTRA_TICKS:    clear_extra_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A pulse phase ends when the limit is reached or the counter is full; a
  // limit of zero therefore behaves as one.
  assign count_inc   = CMP_WIDTH'(tick_count) + CMP_WIDTH'(1);
  assign pulse_limit = (phase == PH_HIGH) ? enable_high_ticks : enable_low_ticks;
  assign pulse_done  = (count_inc >= CMP_WIDTH'(pulse_limit)) || (count_inc >= COUNT_FULL);

  always_comb begin
    if (is_data) begin
      settle_load = bus_width_eight ? SETTLE_WIDTH'(char_settle_ticks) : '0;
    end else begin
      settle_load = SETTLE_WIDTH'(cmd_settle_ticks) +
                    ((byte_value == CLEAR_CMD) ? SETTLE_WIDTH'(clear_extra_ticks) : '0);
    end
  end

  assign settle_dec = (settle_length != '0) ? settle_length - SETTLE_WIDTH'(1) : settle_length;

  always_comb begin
    phase_next                 = phase;
    second_nibble_pending_next = second_nibble_pending;
    tick_count_next            = tick_count;
    held_byte_next             = held_byte;
    held_select_next           = held_select;
    settle_length_next         = settle_length;
    dropped                    = 1'b0;
    if (func) begin
      if (phase != PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        held_byte_next             = byte_value;
        held_select_next           = is_data;
        second_nibble_pending_next = ~bus_width_eight;
        settle_length_next         = settle_load;
        tick_count_next            = '0;
        phase_next                 = PH_HIGH;
      end
    end else begin
      unique case (phase)
        PH_HIGH: begin
          tick_count_next = pulse_done ? '0 : count_inc[COUNT_WIDTH-1:0];
          if (pulse_done) begin
            phase_next = PH_LOW;
          end
        end
        PH_LOW: begin
          tick_count_next = pulse_done ? '0 : count_inc[COUNT_WIDTH-1:0];
          if (pulse_done) begin
            if (second_nibble_pending) begin
              second_nibble_pending_next = 1'b0;
              phase_next                 = PH_HIGH;
            end else if (settle_length == '0) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_SETTLE;
            end
          end
        end
        PH_SETTLE: begin
          settle_length_next = settle_dec;
          if (settle_dec == '0) begin
            phase_next = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_IDLE;
      second_nibble_pending <= 1'b0;
      tick_count            <= '0;
      held_byte             <= '0;
      held_select           <= 1'b0;
      settle_length         <= '0;
    end else if (step) begin
      phase                 <= phase_next;
      second_nibble_pending <= second_nibble_pending_next;
      tick_count            <= tick_count_next;
      held_byte             <= held_byte_next;
      held_select           <= held_select_next;
      settle_length         <= settle_length_next;
    end
  end

  // The high nibble shows only while the first of the two pulses is running.
  assign nibble = second_nibble_pending_next ? held_byte_next[7:4] : held_byte_next[3:0];

  always_comb begin
    result.rs_pin   = held_select_next;
    result.en_pin   = (phase_next == PH_HIGH);
    result.busy_res = (phase_next != PH_IDLE);
    result.dropped  = dropped;
    if (bus_width_eight) begin
      result.data_pins = held_byte_next;
    end else if (nibble_on_upper_pins) begin
      result.data_pins = {nibble, 4'b0000};
    end else begin
      result.data_pins = {4'b0000, nibble};
    end
  end

endmodule

// ----- hdl/char_lcd_write_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_unit
// Character LCD parallel write controller with stream ports and a two-entry
// output buffer.
// ----------------------------------------------------------------------------
// Each input beat is either one time tick or a request to write a byte to the
// display as a command or as character data, and each produces exactly one
// output beat carrying the RS, EN and data pin levels that hold after it,
// together with a busy flag and a flag that marks a write refused because a
// transfer or settle wait was still running. The unit accepts one beat per
// clock while the skid entry is empty. Each result is worked out in a single
// combinational pass through the phase and tick counter logic and is then
// registered. A two-entry output buffer keeps the input side taking beats
// while one finished result waits to be taken, so the input stalls only
// when two results are held. Configuration writes take effect at once and
// are meant to be made while the unit is idle.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_unit
  import lcdws_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write port.
  input  logic                       cfg_wr_en,
  input  logic [CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  // Input stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]                 s_axis_tuser,  // [0] func, [1] is_data
  // Output stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] rs_pin, [1] en_pin, [9:2] data_pins, [10] busy_res, [11] dropped,
  // upper bits zero.
  output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

  logic          in_accept;
  logic          out_take;
  lcdws_result_t step_result;

  // Output register and the skid entry behind it.
  logic          out_valid;
  lcdws_result_t out_data;
  logic          skid_valid;
  lcdws_result_t skid_data;

  assign s_axis_tready = ~skid_valid;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_take      = out_valid & m_axis_tready;

  lcdws_sequencer u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .step       (in_accept),
    .func       (s_axis_tuser[0]),
    .byte_value (s_axis_tdata),
    .is_data    (s_axis_tuser[1]),
    .result     (step_result)
  );

  // When the skid entry is full the input is stalled, so a taken output beat
  // is refilled from the skid entry; otherwise a new result goes to the output
  // register if it is free or being emptied, and to the skid entry if not.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_accept) begin
        out_data <= step_result;
      end
    end else if (in_accept) begin
      if (out_valid) begin
        skid_data <= step_result;
      end else begin
        out_data <= step_result;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_WIDTH'(out_data);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the character LCD write sequencer.
// ----------------------------------------------------------------------------
// Input beats are ticks and byte write requests. Each accepted beat is run
// through a cycle-free model of the sequencer kept in this file, and the pin
// levels it should leave behind are queued in order. Every output beat is
// compared field by field with the oldest queued levels. A short table of
// hand-picked beats and register writes comes first. Randomised phases
// follow, each with its own register setting, and two long runs keep the
// pulse and settle counters going over many ticks. Both stream sides idle
// at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import lcdws_pkg::*;

  localparam int     CLK_HALF        = 10;
  localparam int     RESET_CYCLES    = 5;
  localparam longint CYCLE_LIMIT     = 4_000_000;
  localparam int     RANDOM_PHASES   = 10;
  localparam int     PHASE_ITEMS     = 65;
  localparam int     HOLD_PHASE      = 2;
  localparam int     LONG_RUN_PHASE  = 5;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     SHOW_MISMATCHES = 10;
  localparam int     DRAIN_CYCLES    = 8;

  // Input beat kinds and register select levels.
  localparam bit FUNC_TICK  = 1'b0;
  localparam bit FUNC_WRITE = 1'b1;
  localparam bit SEL_CMD    = 1'b0;
  localparam bit SEL_DATA   = 1'b1;

  // Phases of one byte transfer as the model sees them.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_PULSE_HIGH,
    SEQ_PULSE_LOW,
    SEQ_SETTLE
  } seq_phase_e;

  // Ways in which the receiver withholds tready.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_COMB,
    STALL_SPARSE
  } stall_mode_e;

  typedef enum logic {
    ROW_BEAT,
    ROW_REG
  } row_kind_e;

  // One row of the directed table: either a beat repeated reps times or a
  // register write. Where typed is set, want holds levels worked out by hand.
  typedef struct {
    row_kind_e                 kind;
    logic [CFG_ADDR_WIDTH-1:0] reg_index;
    logic [CFG_DATA_WIDTH-1:0] reg_value;
    bit                        func;
    logic [7:0]                value;
    bit                        sel;
    int unsigned               reps;
    bit                        typed;
    lcdws_result_t             want;
  } stim_row_t;

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       cfg_wr_en     = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0]  cfg_addr      = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata     = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata  = '0;  // [7:0] byte_value
  logic [1:0]                 s_axis_tuser  = '0;  // [0] func, [1] is_data
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [0] rs_pin, [1] en_pin, [9:2] data_pins, [10] busy_res, [11] dropped
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

  always #CLK_HALF clk = ~clk;

  char_lcd_write_sequencer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Model of the sequencer. Register copies start at their reset values.
  // --------------------------------------------------------------------------
  bit                      reg_eight       = 1'b1;
  bit                      reg_upper       = 1'b1;
  logic [15:0]             reg_en_high     = 16'd2;
  logic [15:0]             reg_en_low      = 16'd2;
  logic [15:0]             reg_char_settle = 16'd1;
  logic [15:0]             reg_cmd_settle  = 16'd2;
  logic [15:0]             reg_clear_extra = 16'd5;

  seq_phase_e              seq_phase         = SEQ_IDLE;
  bit                      seq_second_nibble = 1'b0;
  logic [COUNT_WIDTH-1:0]  seq_ticks         = '0;
  logic [7:0]              seq_byte          = '0;
  bit                      seq_select        = 1'b0;
  logic [SETTLE_WIDTH-1:0] seq_settle        = '0;

  // Counts one tick of a pulse phase. The phase ends when the count reaches
  // its limit or the counter is full; a limit of zero therefore acts as one.
  function automatic bit pulse_elapsed(input logic [15:0] limit);
    longint unsigned nxt;
    longint unsigned full;
    nxt  = 64'(seq_ticks) + 64'd1;
    full = (64'd1 << COUNT_WIDTH) - 64'd1;
    if (nxt >= 64'(limit) || nxt >= full) begin
      seq_ticks = '0;
      return 1'b1;
    end
    seq_ticks = nxt[COUNT_WIDTH-1:0];
    return 1'b0;
  endfunction

  // Bus levels follow the present width and nibble settings. In 4-bit mode
  // the high nibble shows while the first pulse is still to finish.
  function automatic logic [7:0] bus_levels();
    logic [3:0] nib;
    if (reg_eight)
      return seq_byte;
    nib = seq_second_nibble ? seq_byte[7:4] : seq_byte[3:0];
    return reg_upper ? {nib, 4'h0} : {4'h0, nib};
  endfunction

  // Applies one input beat to the model and returns the levels left after it.
  function automatic lcdws_result_t predict_pin_levels(input bit func,
                                                       input logic [7:0] value,
                                                       input bit sel);
    lcdws_result_t levels;
    bit            refused;
    refused = 1'b0;
    if (func == FUNC_WRITE) begin
      if (seq_phase != SEQ_IDLE) begin
        // A write while a transfer or settle is running is thrown away.
        refused = 1'b1;
      end else begin
        seq_byte          = value;
        seq_select        = sel;
        seq_second_nibble = !reg_eight;
        // The settle time is fixed here, at the moment the write is taken.
        if (sel == SEL_DATA) begin
          seq_settle = reg_eight ? SETTLE_WIDTH'(reg_char_settle) : '0;
        end else begin
          seq_settle = SETTLE_WIDTH'(reg_cmd_settle);
          if (value == CLEAR_CMD)
            seq_settle = seq_settle + SETTLE_WIDTH'(reg_clear_extra);
        end
        seq_ticks = '0;
        seq_phase = SEQ_PULSE_HIGH;
      end
    end else begin
      case (seq_phase)
        SEQ_PULSE_HIGH: begin
          if (pulse_elapsed(reg_en_high))
            seq_phase = SEQ_PULSE_LOW;
        end
        SEQ_PULSE_LOW: begin
          if (pulse_elapsed(reg_en_low)) begin
            if (seq_second_nibble) begin
              seq_second_nibble = 1'b0;
              seq_phase         = SEQ_PULSE_HIGH;
            end else if (seq_settle == '0) begin
              seq_phase = SEQ_IDLE;
            end else begin
              seq_phase = SEQ_SETTLE;
            end
          end
        end
        SEQ_SETTLE: begin
          if (seq_settle != '0)
            seq_settle = seq_settle - 1'b1;
          if (seq_settle == '0)
            seq_phase = SEQ_IDLE;
        end
        default: ;
      endcase
    end
    levels.rs_pin    = seq_select;
    levels.en_pin    = (seq_phase == SEQ_PULSE_HIGH);
    levels.data_pins = bus_levels();
    levels.busy_res  = (seq_phase != SEQ_IDLE);
    levels.dropped   = refused;
    return levels;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bookkeeping.
  // --------------------------------------------------------------------------
  lcdws_result_t pin_levels_due[$];
  int            fail_count  = 0;
  longint        cycle_count = 0;
  int unsigned   burst_left  = 0;
  bit            flood       = 1'b0;
  bit            hold_toggle = 1'b0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= SHOW_MISMATCHES)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s expected %h got %h", name, want_v, got_v));
  endtask

  // --------------------------------------------------------------------------
  // Output side: each beat taken is checked against the oldest levels due.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    lcdws_result_t got;
    lcdws_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RESULT_WIDTH-1:0];
      if (pin_levels_due.size() == 0) begin
        report_mismatch($sformatf("output beat %h with nothing outstanding", got));
      end else begin
        want = pin_levels_due.pop_front();
        check_field("rs_pin", 8'(want.rs_pin), 8'(got.rs_pin));
        check_field("en_pin", 8'(want.en_pin), 8'(got.en_pin));
        check_field("data_pins", want.data_pins, got.data_pins);
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("dropped", 8'(want.dropped), 8'(got.dropped));
      end
    end
  end

  // Receiver back-pressure. Windows of random length pick a stall mode; a
  // flip of hold_toggle starts one long hold-off counted here, during which
  // the sender keeps offering so that the output buffer fills and tready on
  // the input side falls.
  int unsigned hold_left   = 0;
  bit          hold_seen   = 1'b0;
  int unsigned window_left = 0;
  int unsigned stall_count = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        stall_mode  <= stall_mode_e'($urandom_range(0, 3));
        window_left <= $urandom_range(16, 96);
      end else begin
        window_left <= window_left - 1;
      end
      stall_count <= stall_count + 1;
      case (stall_mode)
        STALL_NONE:   m_axis_tready <= 1'b1;
        STALL_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        STALL_COMB:   m_axis_tready <= (stall_count % 4) != 0;
        STALL_SPARSE: m_axis_tready <= (stall_count % 5) == 0;
        default:      m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Run limit: the run is stopped and marked failed once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** char_lcd_write_sequencer_unit: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Offers one beat, waits until it is taken and queues the levels it should
  // cause. Outside a long run the sender works in bursts; some bursts are
  // long enough to give stretches with no idling at all.
  task automatic offer_beat(input bit func, input logic [7:0] value,
                            input bit sel, input bit typed,
                            input lcdws_result_t want);
    int unsigned   gap;
    lcdws_result_t predicted;
    if (!flood && burst_left == 0) begin
      gap        = $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left != 0)
      burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {sel, func};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_pin_levels(func, value, sel);
    pin_levels_due.push_back(typed ? want : predicted);
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_WIDTH-1:0] index,
                                input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (index)
      REG_BUS_WIDTH_EIGHT:      reg_eight       = value[0];
      REG_NIBBLE_ON_UPPER_PINS: reg_upper       = value[0];
      REG_ENABLE_HIGH_TICKS:    reg_en_high     = value;
      REG_ENABLE_LOW_TICKS:     reg_en_low      = value;
      REG_CHAR_SETTLE_TICKS:    reg_char_settle = value;
      REG_CMD_SETTLE_TICKS:     reg_cmd_settle  = value;
      REG_CLEAR_EXTRA_TICKS:    reg_clear_extra = value;
      default: ;
    endcase
  endtask

  task automatic program_registers(input bit eight, input bit upper,
                                   input logic [15:0] en_high,
                                   input logic [15:0] en_low,
                                   input logic [15:0] char_settle,
                                   input logic [15:0] cmd_settle,
                                   input logic [15:0] clear_extra);
    write_register(REG_BUS_WIDTH_EIGHT, 16'(eight));
    write_register(REG_NIBBLE_ON_UPPER_PINS, 16'(upper));
    write_register(REG_ENABLE_HIGH_TICKS, en_high);
    write_register(REG_ENABLE_LOW_TICKS, en_low);
    write_register(REG_CHAR_SETTLE_TICKS, char_settle);
    write_register(REG_CMD_SETTLE_TICKS, cmd_settle);
    write_register(REG_CLEAR_EXTRA_TICKS, clear_extra);
  endtask

  // Pulse lengths stay short in the random phases; zero is picked often, as
  // it must behave exactly like one.
  function automatic logic [15:0] pick_pulse_ticks();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'd1;
      default: return 16'($urandom_range(2, 6));
    endcase
  endfunction

  // One write followed by back-to-back ticks until the transfer is over.
  task automatic run_to_idle(input logic [7:0] value, input bit sel);
    flood = 1'b1;
    offer_beat(FUNC_WRITE, value, sel, 1'b0, '0);
    while (seq_phase != SEQ_IDLE)
      offer_beat(FUNC_TICK, 8'h00, SEL_CMD, 1'b0, '0);
    flood = 1'b0;
  endtask

  // Directed table rows.
  function automatic stim_row_t beat_row(input bit func, input logic [7:0] value,
                                         input bit sel, input int unsigned reps);
    stim_row_t row;
    row       = '{kind: ROW_BEAT, default: '0};
    row.func  = func;
    row.value = value;
    row.sel   = sel;
    row.reps  = reps;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input bit func, input logic [7:0] value,
                                            input bit sel, input bit rs,
                                            input bit en, input logic [7:0] pins,
                                            input bit busy, input bit refused);
    stim_row_t row;
    row                = beat_row(func, value, sel, 1);
    row.typed          = 1'b1;
    row.want.rs_pin    = rs;
    row.want.en_pin    = en;
    row.want.data_pins = pins;
    row.want.busy_res  = busy;
    row.want.dropped   = refused;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_ADDR_WIDTH-1:0] index,
                                        input logic [CFG_DATA_WIDTH-1:0] value);
    stim_row_t row;
    row           = '{kind: ROW_REG, default: '0};
    row.reg_index = index;
    row.reg_value = value;
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t  rows[$];
    bit         was_idle;
    bit         func;
    bit         sel;
    logic [7:0] value;
    int         counted;

    // Reset settings: 8-bit bus, pulses of two ticks high and two low,
    // command settle of two ticks and five more after a clear.
    // A tick straight after reset leaves every pin low and nothing busy.
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 0, 8'h00, 0, 0));
    // All-ones command: EN rises on the beat that carries the write.
    rows.push_back(checked_row(FUNC_WRITE, 8'hFF, SEL_CMD, 0, 1, 8'hFF, 1, 0));
    // A data write during the pulse is refused and changes nothing.
    rows.push_back(checked_row(FUNC_WRITE, 8'h00, SEL_DATA, 0, 1, 8'hFF, 1, 1));
    // Two ticks high, two low, then the two-tick command settle.
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 1, 8'hFF, 1, 0));
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 0, 8'hFF, 1, 0));
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 0, 8'hFF, 1, 0));
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 0, 8'hFF, 1, 0));
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 0, 8'hFF, 1, 0));
    rows.push_back(checked_row(FUNC_TICK, 8'h00, SEL_CMD, 0, 0, 8'hFF, 0, 0));
    // The clear command takes the longer settle.
    rows.push_back(checked_row(FUNC_WRITE, CLEAR_CMD, SEL_CMD, 0, 1, 8'h01, 1, 0));
    rows.push_back(beat_row(FUNC_TICK, 8'h00, SEL_CMD, 12));
    // Data byte in 8-bit mode with the char settle, then idle ticks.
    rows.push_back(beat_row(FUNC_WRITE, 8'hA5, SEL_DATA, 1));
    rows.push_back(beat_row(FUNC_TICK, 8'h00, SEL_CMD, 6));
    // 4-bit bus on the lower pins, with zero-length pulses.
    rows.push_back(reg_row(REG_BUS_WIDTH_EIGHT, 16'd0));
    rows.push_back(reg_row(REG_NIBBLE_ON_UPPER_PINS, 16'd0));
    rows.push_back(reg_row(REG_ENABLE_HIGH_TICKS, 16'd0));
    rows.push_back(reg_row(REG_ENABLE_LOW_TICKS, 16'd0));
    rows.push_back(beat_row(FUNC_WRITE, 8'h3C, SEL_DATA, 1));
    rows.push_back(beat_row(FUNC_WRITE, 8'h7E, SEL_CMD, 1));
    rows.push_back(beat_row(FUNC_TICK, 8'h00, SEL_CMD, 6));
    // Upper pins and a clear command sent as two nibbles.
    rows.push_back(reg_row(REG_NIBBLE_ON_UPPER_PINS, 16'd1));
    rows.push_back(beat_row(FUNC_WRITE, CLEAR_CMD, SEL_CMD, 1));
    rows.push_back(beat_row(FUNC_TICK, 8'h00, SEL_CMD, 14));
    // Back to 8 bits with no char settle: the data byte ends straight away.
    rows.push_back(reg_row(REG_BUS_WIDTH_EIGHT, 16'd1));
    rows.push_back(reg_row(REG_CHAR_SETTLE_TICKS, 16'd0));
    rows.push_back(beat_row(FUNC_WRITE, 8'h5A, SEL_DATA, 1));
    rows.push_back(beat_row(FUNC_TICK, 8'h00, SEL_CMD, 4));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        wait_for_results();
        write_register(rows[i].reg_index, rows[i].reg_value);
      end else begin
        repeat (rows[i].reps)
          offer_beat(rows[i].func, rows[i].value, rows[i].sel, rows[i].typed,
                     rows[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Every phase starts from an empty pipeline: the sender pauses here.
      wait_for_results();
      if (ph == LONG_RUN_PHASE) begin
        // Long pulses and a long char settle on one data byte.
        program_registers(1'b1, 1'b0, 16'd20, 16'd20, 16'd12, 16'd0, 16'd0);
        run_to_idle(8'hFF, SEL_DATA);
        wait_for_results();
        // Long command settle plus clear extra, 4-bit on the upper pins.
        program_registers(1'b0, 1'b1, 16'd1, 16'd1, 16'd0, 16'd9, 16'd11);
        run_to_idle(CLEAR_CMD, SEL_CMD);
        wait_for_results();
      end
      program_registers(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        pick_pulse_ticks(), pick_pulse_ticks(),
                        16'($urandom_range(0, 5)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 9)));
      if (ph == HOLD_PHASE)
        hold_toggle <= ~hold_toggle;

      // Mostly whole transfers: a write when idle, then ticks, with the odd
      // write thrown in while busy. Ticks on an idle block are not counted.
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        was_idle = (seq_phase == SEQ_IDLE);
        func     = was_idle ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
        value    = ($urandom_range(0, 3) == 0) ? CLEAR_CMD : 8'($urandom_range(0, 255));
        sel      = 1'($urandom_range(0, 1));
        offer_beat(func, value, sel, 1'b0, '0);
        if (func || !was_idle)
          counted++;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pin_levels_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pin_levels_due.size()));
    if (fail_count == 0) begin
      $display("** char_lcd_write_sequencer_unit: PASSED **");
    end else begin
      $display("** char_lcd_write_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- char_lcd_write_sequencer_unit.f -----
hdl/lcdws_pkg.sv
hdl/lcdws_sequencer.sv
hdl/char_lcd_write_sequencer_unit.sv
test/tb_top.sv
